[rtl/pcsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsm_pkg
// shared types and constants for the cluster shape moments block
// ----------------------------------------------------------------------------
package pcsm_pkg;

  localparam int unsigned XW = 10;
  localparam int unsigned YW = 9;
  localparam int unsigned CNTW = 9;
  localparam int unsigned SIGW = 15;
  localparam int unsigned STW = 2;

  localparam logic [STW-1:0] ST_OK = 2'd0;
  localparam logic [STW-1:0] ST_SINGLE = 2'd1;
  localparam logic [STW-1:0] ST_OVERFLOW = 2'd2;

  localparam logic [SIGW-1:0] SIGMA_MAX = 15'h7fff;

  // hit entry passed from the input queue front to the accumulating and finishing back end
  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          last;
  } hit_t;

endpackage

[rtl/pcsm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsm_front
// input stage and two entry hit queue
// ----------------------------------------------------------------------------
module pcsm_front
  import pcsm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  hit_t in_hit_i,
  output logic q_valid_o,
  input  logic q_ready_i,
  output hit_t q_hit_o
);

  hit_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_hit_o = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_hit_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/pcsm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsm_back
// moment accumulation and serial finishing (divide and square root)
// ----------------------------------------------------------------------------
module pcsm_back
  import pcsm_pkg::*;
#(
  parameter int unsigned MAX_HITS = 256,
  parameter int unsigned FRAC_BITS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  hit_t            q_hit_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CNTW-1:0] hit_count_o,
  output logic [XW-1:0]   x_mean_o,
  output logic [YW-1:0]   y_mean_o,
  output logic [SIGW-1:0] sigma_x_o,
  output logic [SIGW-1:0] sigma_y_o,
  output logic [SIGW-1:0] sigma_diag_o,
  output logic [SIGW-1:0] sigma_antidiag_o,
  output logic [STW-1:0]  status_o
);

  localparam int unsigned NW = $clog2(MAX_HITS + 1);
  localparam int unsigned SXW = XW + NW;
  localparam int unsigned SYW = YW + NW;
  localparam int unsigned SXXW = 2 * XW + NW;
  localparam int unsigned SYYW = 2 * YW + NW;
  localparam int unsigned SXYW = XW + YW + NW;
  // diagonal sums and variance numerators
  localparam int unsigned SDW = SXW + 1;
  localparam int unsigned QW = 2 * SDW + 2;
  localparam int unsigned DW = NW + QW;
  // radicand width rounded up to even so digit pairs line up with bit 0
  localparam int unsigned NUMW = ((DW + 2 * FRAC_BITS + 1) / 2) * 2;
  localparam int unsigned RW = (NUMW + 1) / 2;
  localparam int unsigned PW = 2 * NW;
  localparam int unsigned IW = $clog2(NUMW + 1);

  // state codes
  localparam logic [2:0] S_ACC = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_SQR = 3'd3;
  localparam logic [2:0] S_NXT = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0]      st_q;
  logic [NW-1:0]   n_q;
  logic [SXW-1:0]  sx_q;
  logic [SYW-1:0]  sy_q;
  logic [SXXW-1:0] sxx_q;
  logic [SYYW-1:0] syy_q;
  logic [SXYW-1:0] sxy_q;
  logic            ovf_q;
  logic [1:0]      ch_q;
  logic [1:0]      ph_q;
  logic [DW-1:0]   d_q;
  logic [PW-1:0]   den_q;
  logic [NUMW-1:0] rem_q, quo_q;
  logic [IW-1:0]   it_q;
  logic [RW-1:0]   root_q;
  logic [NUMW+1:0] sr_rem_q;
  logic [SIGW-1:0] sig_q [4];
  logic [SXW-1:0]  xm_q;
  logic [SYW-1:0]  ym_q;
  logic            mean_ph_q;

  logic            take;

  assign q_ready_o = (st_q == S_ACC);
  assign take = q_valid_i && q_ready_o;

  // operands for the channel being finished
  logic [SXXW+1:0] s2_sel;
  logic [SDW-1:0]  s1_sel;
  logic [SXYW:0]   xy2;
  assign xy2 = {sxy_q, 1'b0};
  always_comb begin
    s2_sel = '0;
    s1_sel = '0;
    case (ch_q)
      2'd0: begin
        s2_sel = (SXXW+2)'(sxx_q);
        s1_sel = SDW'(sx_q);
      end
      2'd1: begin
        s2_sel = (SXXW+2)'(syy_q);
        s1_sel = SDW'(sy_q);
      end
      2'd2: begin
        s2_sel = (SXXW+2)'(sxx_q) + (SXXW+2)'(syy_q) + (SXXW+2)'(xy2);
        s1_sel = SDW'(sx_q) + SDW'(sy_q);
      end
      default: begin
        // sum of (y-x)^2 is never negative
        s2_sel = (SXXW+2)'(sxx_q) + (SXXW+2)'(syy_q) - (SXXW+2)'(xy2);
        s1_sel = (sy_q >= sx_q) ? SDW'(sy_q) - SDW'(sx_q) : SDW'(sx_q) - SDW'(sy_q);
      end
    endcase
  end

  // restoring divide step and sqrt step
  logic [NUMW:0]   div_trial;
  logic [NUMW-1:0] div_shift;
  assign div_shift = {rem_q[NUMW-2:0], quo_q[NUMW-1]};
  assign div_trial = {1'b0, div_shift} - (NUMW+1)'(den_q);

  logic [NUMW+1:0] sq_trial;
  logic [NUMW+1:0] sq_cand;
  logic [1:0]      sq_pair;
  assign sq_pair = {quo_q[NUMW-1], (NUMW > 1) ? quo_q[NUMW-2] : 1'b0};
  assign sq_cand = {sr_rem_q[NUMW-1:0], sq_pair};
  assign sq_trial = sq_cand - (NUMW+2)'({root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_ACC;
      n_q <= '0;
      sx_q <= '0;
      sy_q <= '0;
      sxx_q <= '0;
      syy_q <= '0;
      sxy_q <= '0;
      ovf_q <= 1'b0;
      ch_q <= '0;
      ph_q <= '0;
      it_q <= '0;
      mean_ph_q <= 1'b0;
    end else begin
      unique case (st_q)
        S_ACC: begin
          if (take) begin
            if (n_q == NW'(MAX_HITS)) begin
              ovf_q <= 1'b1;
            end else begin
              n_q <= n_q + 1'b1;
              sx_q <= sx_q + SXW'(q_hit_i.x);
              sy_q <= sy_q + SYW'(q_hit_i.y);
              sxx_q <= sxx_q + SXXW'(q_hit_i.x) * SXXW'(q_hit_i.x);
              syy_q <= syy_q + SYYW'(q_hit_i.y) * SYYW'(q_hit_i.y);
              sxy_q <= sxy_q + SXYW'(q_hit_i.x) * SXYW'(q_hit_i.y);
            end
            if (q_hit_i.last) begin
              st_q <= S_MUL;
              ch_q <= '0;
              ph_q <= '0;
              mean_ph_q <= 1'b1;
            end
          end
        end
        S_MUL: begin
          // phase 0: n*s2, phase 1: s1^2, phase 2: divisor setup
          unique case (ph_q)
            2'd0: begin
              d_q <= DW'(n_q) * DW'(s2_sel);
              ph_q <= 2'd1;
            end
            2'd1: begin
              d_q <= d_q - DW'(s1_sel) * DW'(s1_sel);
              ph_q <= 2'd2;
            end
            default: begin
              ph_q <= 2'd0;
              st_q <= S_DIV;
              it_q <= IW'(NUMW);
              rem_q <= '0;
              if (mean_ph_q) begin
                den_q <= PW'(n_q);
                quo_q <= NUMW'(ch_q[0] ? sy_q : sx_q);
              end else begin
                den_q <= PW'(n_q) * PW'(n_q - 1'b1);
                quo_q <= NUMW'(d_q) << (2 * FRAC_BITS);
              end
            end
          endcase
        end
        S_DIV: begin
          if (!div_trial[NUMW]) begin
            rem_q <= div_trial[NUMW-1:0];
            quo_q <= {quo_q[NUMW-2:0], 1'b1};
          end else begin
            rem_q <= div_shift;
            quo_q <= {quo_q[NUMW-2:0], 1'b0};
          end
          if (it_q != IW'(1)) begin
            it_q <= it_q - 1'b1;
          end else if (mean_ph_q) begin
            it_q <= '0;
            st_q <= S_NXT;
          end else begin
            st_q <= S_SQR;
            it_q <= IW'(RW);
            root_q <= '0;
            sr_rem_q <= '0;
          end
        end
        S_SQR: begin
          // quotient is left shifted two bits per step as digit pairs
          quo_q <= quo_q << 2;
          if (!sq_trial[NUMW+1]) begin
            sr_rem_q <= sq_trial;
            root_q <= {root_q[RW-2:0], 1'b1};
          end else begin
            sr_rem_q <= sq_cand;
            root_q <= {root_q[RW-2:0], 1'b0};
          end
          it_q <= it_q - 1'b1;
          if (it_q == IW'(1)) st_q <= S_NXT;
        end
        S_NXT: begin
          if (mean_ph_q) begin
            if (ch_q[0]) ym_q <= SYW'(quo_q);
            else xm_q <= SXW'(quo_q);
          end else begin
            sig_q[ch_q] <= (root_q > RW'(SIGMA_MAX)) ? SIGMA_MAX : SIGW'(root_q);
          end
          if (mean_ph_q && !ch_q[0]) begin
            ch_q <= 2'd1;
            st_q <= S_MUL;
            ph_q <= 2'd2;
          end else if (mean_ph_q) begin
            mean_ph_q <= 1'b0;
            ch_q <= 2'd0;
            st_q <= (n_q < NW'(2)) ? S_OUT : S_MUL;
          end else if (ch_q == 2'd3) begin
            st_q <= S_OUT;
          end else begin
            ch_q <= ch_q + 1'b1;
            st_q <= S_MUL;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            st_q <= S_ACC;
            n_q <= '0;
            sx_q <= '0;
            sy_q <= '0;
            sxx_q <= '0;
            syy_q <= '0;
            sxy_q <= '0;
            ovf_q <= 1'b0;
          end
        end
        default: st_q <= S_ACC;
      endcase
    end
  end

  logic single;
  assign single = (n_q < NW'(2));
  assign out_valid_o = (st_q == S_OUT);
  assign hit_count_o = CNTW'(n_q);
  assign x_mean_o = XW'(xm_q);
  assign y_mean_o = YW'(ym_q);
  assign sigma_x_o = single ? '0 : sig_q[0];
  assign sigma_y_o = single ? '0 : sig_q[1];
  assign sigma_diag_o = single ? '0 : sig_q[2];
  assign sigma_antidiag_o = single ? '0 : sig_q[3];
  assign status_o = ovf_q ? ST_OVERFLOW : (single ? ST_SINGLE : ST_OK);

endmodule

[rtl/pixel_cluster_shape_moments_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_cluster_shape_moments_core
// cluster centroid and sample standard deviations from pixel hits
// ----------------------------------------------------------------------------
// hits stream in one request at a time; non-final hits pass through a two entry
// queue into the accumulator, which takes them back to back while it is not
// finishing a cluster. the final hit starts a serial finish on one shared restoring
// divider and a bit-serial square root: two mean divisions of NUMW steps each,
// then four variance channels, each a multiply setup, NUMW divide steps and
// NUMW/2 root steps (60 plus 30 at default widths); a single hit cluster skips
// the variance channels.
// the queue keeps taking hits during that finish until it fills.
module pixel_cluster_shape_moments_core
  import pcsm_pkg::*;
#(
  parameter int unsigned MAX_HITS = 256,
  parameter int unsigned FRAC_BITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // x_coord[9:0], y_coord[18:10], zeros
  input  logic        s_axis_tlast_i,  // last_hit
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o   // hit_count, x_mean, y_mean, sigma_x,
                                       // sigma_y, sigma_diag, sigma_antidiag,
                                       // status, zeros
);

  hit_t in_hit, q_hit;
  logic q_valid, q_ready;
  logic [CNTW-1:0] cnt;
  logic [XW-1:0] xm;
  logic [YW-1:0] ym;
  logic [SIGW-1:0] sx, sy, sd, sa;
  logic [STW-1:0] st;

  assign in_hit.x = s_axis_tdata_i[9:0];
  assign in_hit.y = s_axis_tdata_i[18:10];
  assign in_hit.last = s_axis_tlast_i;

  pcsm_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o), .in_hit_i(in_hit),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_hit_o(q_hit)
  );

  pcsm_back #(.MAX_HITS(MAX_HITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_hit_i(q_hit),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .hit_count_o(cnt), .x_mean_o(xm), .y_mean_o(ym),
    .sigma_x_o(sx), .sigma_y_o(sy), .sigma_diag_o(sd), .sigma_antidiag_o(sa),
    .status_o(st)
  );

  assign m_axis_tdata_o = {6'd0, st, sa, sd, sy, sx, ym, xm, cnt};

endmodule

[rtl/pcsm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsm_sva
// port level checks for the cluster shape moments core
// ----------------------------------------------------------------------------
module pcsm_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [95:0] m_axis_tdata_o
);

  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped while stalled");

  ap_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[89:88] != 2'd3)
    else $error("bad status code");

  ap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[8:0] != 9'd0 || m_axis_tdata_o[89:88] != 2'd0)
    else $error("empty cluster reported");

  ap_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[89:88] == 2'd1 |-> m_axis_tdata_o[87:28] == '0)
    else $error("single hit with nonzero sigma");

endmodule

bind pixel_cluster_shape_moments_core pcsm_sva u_sva (.*);

[sim/pcsm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsm_checker
// watches both streams, predicts cluster moments and compares each result
// ----------------------------------------------------------------------------
module pcsm_checker
  import pcsm_pkg::*;
#(
  parameter int unsigned MAX_HITS = 256,
  parameter int unsigned FRAC_BITS = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [23:0]  s_tdata_i,
  input  logic         s_tlast_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [95:0]  m_tdata_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic [CNTW-1:0] count;
    logic [XW-1:0]   xm;
    logic [YW-1:0]   ym;
    logic [SIGW-1:0] sx;
    logic [SIGW-1:0] sy;
    logic [SIGW-1:0] sd;
    logic [SIGW-1:0] sa;
    logic [STW-1:0]  st;
  } moments_t;

  moments_t cluster_q[$];
  longint unsigned n_acc = 0, sx_acc = 0, sy_acc = 0;
  longint unsigned sxx_acc = 0, syy_acc = 0, sxy_acc = 0;
  bit ovf_acc = 0;
  int fails = 0;

  assign fail_count_o = fails;
  assign pending_o = cluster_q.size();

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [SIGW-1:0] spread(longint d, longint unsigned n);
    longint unsigned q, r;
    if (d <= 0) return '0;
    q = (longint'(d) << (2 * FRAC_BITS)) / (n * (n - 1));
    r = floor_root(q);
    return (r > SIGMA_MAX) ? SIGMA_MAX : r[SIGW-1:0];
  endfunction

  task automatic take_hit(logic [XW-1:0] x, logic [YW-1:0] y, logic last);
    moments_t m;
    longint n, a, b, aa, bb, ab;
    if (n_acc >= MAX_HITS) begin
      ovf_acc = 1;
    end else begin
      n_acc++;
      sx_acc += x;
      sy_acc += y;
      sxx_acc += x * x;
      syy_acc += y * y;
      sxy_acc += x * y;
    end
    if (!last) return;
    n = n_acc; a = sx_acc; b = sy_acc; aa = sxx_acc; bb = syy_acc; ab = sxy_acc;
    m.count = n[CNTW-1:0];
    m.xm = XW'(sx_acc / n_acc);
    m.ym = YW'(sy_acc / n_acc);
    if (n < 2) begin
      m.sx = '0; m.sy = '0; m.sd = '0; m.sa = '0;
    end else begin
      m.sx = spread(n * aa - a * a, n);
      m.sy = spread(n * bb - b * b, n);
      m.sd = spread(n * (aa + bb + 2 * ab) - (a + b) * (a + b), n);
      m.sa = spread(n * (aa + bb - 2 * ab) - (b - a) * (b - a), n);
    end
    m.st = ovf_acc ? ST_OVERFLOW : (n < 2 ? ST_SINGLE : ST_OK);
    cluster_q = {cluster_q, m};
    n_acc = 0; sx_acc = 0; sy_acc = 0; sxx_acc = 0; syy_acc = 0; sxy_acc = 0;
    ovf_acc = 0;
  endtask

  always @(posedge clk_i) begin
    moments_t got, want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i)
        take_hit(s_tdata_i[9:0], s_tdata_i[18:10], s_tlast_i);
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[$bits(moments_t)-1:0];
        // tdata packs hit_count lowest, so rebuild field by field
        got.count = m_tdata_i[8:0];
        got.xm = m_tdata_i[18:9];
        got.ym = m_tdata_i[27:19];
        got.sx = m_tdata_i[42:28];
        got.sy = m_tdata_i[57:43];
        got.sd = m_tdata_i[72:58];
        got.sa = m_tdata_i[87:73];
        got.st = m_tdata_i[89:88];
        if (cluster_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result %h", m_tdata_i);
        end else begin
          want = cluster_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("mismatch exp n=%0d xm=%0d ym=%0d sx=%0d sy=%0d sd=%0d sa=%0d st=%0d",
                       want.count, want.xm, want.ym, want.sx, want.sy, want.sd, want.sa,
                       want.st, " / act n=%0d xm=%0d ym=%0d sx=%0d sy=%0d sd=%0d sa=%0d st=%0d",
                       got.count, got.xm, got.ym, got.sx, got.sy, got.sd, got.sa, got.st);
          end
        end
      end
    end
  end

endmodule

[sim/tb_pixel_cluster_shape_moments_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_cluster_shape_moments_core
// streams pixel clusters into the moments core under random back pressure
// ----------------------------------------------------------------------------
module tb_pixel_cluster_shape_moments_core;
  import pcsm_pkg::*;

  localparam int unsigned MAXH = 256;
  localparam int WATCHDOG = 20000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [23:0]  s_tdata = '0;
  logic         s_tlast = 0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [95:0]  m_tdata;
  int           fails, pending;
  int           send_idle = 0, recv_idle = 0;
  int           stall_cycles = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  pixel_cluster_shape_moments_core #(.MAX_HITS(MAXH), .FRAC_BITS(4)) DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tlast_i(s_tlast),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata)
  );

  pcsm_checker #(.MAX_HITS(MAXH), .FRAC_BITS(4)) u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .s_tlast_i(s_tlast),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .fail_count_o(fails), .pending_o(pending)
  );

  // receiver stalls at random
  always @(posedge clk_i) m_tready <= ($urandom_range(99) >= recv_idle);

  // watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG) begin
      $display("pixel_cluster_shape_moments_core regression: fail");
      $finish;
    end
  end

  // one hit request; idle gaps before it, then hold until accepted
  task automatic send_hit(logic [9:0] x, logic [8:0] y, logic last);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk_i);
    end
    s_tvalid <= 1;
    s_tdata <= {5'd0, y, x};
    s_tlast <= last;
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic release_bus();
    s_tvalid <= 0;
    @(posedge clk_i);
  endtask

  // cluster of n hits around a center with a given spread
  task automatic send_cluster(int n, int spread);
    int cx, cy, x, y;
    cx = $urandom_range(1023);
    cy = $urandom_range(511);
    for (int i = 0; i < n; i++) begin
      x = cx + $urandom_range(2 * spread) - spread;
      y = cy + $urandom_range(2 * spread) - spread;
      if (x < 0) x = 0;
      if (x > 1023) x = 1023;
      if (y < 0) y = 0;
      if (y > 511) y = 511;
      send_hit(x[9:0], y[8:0], i == n - 1);
    end
  endtask

  initial begin
    int sent, n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: single hit, corner extremes, max spread, full capacity, overflow
    send_hit(10'd0, 9'd0, 1);
    send_hit(10'd1023, 9'd511, 1);
    send_hit(10'd0, 9'd0, 0);
    send_hit(10'd1023, 9'd511, 1);
    send_hit(10'd1023, 9'd0, 0);
    send_hit(10'd0, 9'd511, 1);
    send_hit(10'd5, 9'd5, 0);
    send_hit(10'd5, 9'd5, 0);
    send_hit(10'd5, 9'd5, 1);
    send_hit(10'h2aa, 9'h155, 0);
    send_hit(10'h155, 9'h0aa, 1);
    for (int i = 0; i < MAXH; i++) send_hit(10'(i * 4), 9'(i * 2), i == MAXH - 1);
    for (int i = 0; i < MAXH + 3; i++) send_hit(10'(1023 - i), 9'd7, i == MAXH + 2);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 31 : (ph == 1) ? 58 : 0;
      recv_idle = (ph == 0) ? 58 : (ph == 1) ? 31 : 0;
      sent = 0;
      while (sent < 300) begin
        case ($urandom_range(9))
          0: n = 1;
          1: n = $urandom_range(250, 262);
          default: n = $urandom_range(2, 12);
        endcase
        send_cluster(n, $urandom_range(1) ? 3 : 600);
        sent += n;
      end
    end
    release_bus();

    while (pending != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (fails == 0) $display("pixel_cluster_shape_moments_core regression: pass");
    else $display("pixel_cluster_shape_moments_core regression: fail");
    $finish;
  end

endmodule
